[rtl/core/nearest_palette_color_mapper_top_macros.svh]
// Assertion macros shared by the mapper RTL.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define NPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define NPCM_NEVER(lbl, cond, msg) \
  `NPCM_ASSERT(lbl, !(cond), msg)
`else
`define NPCM_ASSERT(lbl, prop, msg)
`define NPCM_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/core/npcm_pkg.sv]
package npcm_pkg;

  localparam int unsigned ColorW   = 8;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned DistW    = 18;
  localparam int unsigned PsizeW   = 9;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [PsizeW-1:0] PsizeReset = 9'd256;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] entry_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } item_t;

endpackage

[rtl/core/npcm_front.sv]
module npcm_front #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // entry_index [7:0], red [15:8], green [23:16], blue [31:24]
  input  logic [31:0]                          s_axis_tdata,
  // op [0]
  input  logic                                 s_axis_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [npcm_pkg::PaddrW-1:0]          paddr,
  input  logic [npcm_pkg::ApbDataW-1:0]        pwdata,
  output logic [npcm_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready,
  output logic                                 push_o,
  output npcm_pkg::item_t                      item_o,
  input  logic                                 full_i,
  output logic [$clog2(PALETTE_DEPTH)-1:0]     last_idx_o
);
  import npcm_pkg::*;

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);

  logic [PsizeW-1:0] palette_size_q, palette_size_d;
  logic              cfg_wr;
  logic              sel_size;
  logic              accept;
  logic              in_range;

  assign pready   = 1'b1;
  assign sel_size = (paddr[2] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && pready && sel_size;

  always_comb begin
    palette_size_d = palette_size_q;
    if (cfg_wr) begin
      palette_size_d = pwdata[PsizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= PsizeReset;
    end else begin
      palette_size_q <= palette_size_d;
    end
  end

  assign prdata = sel_size ? ApbDataW'(palette_size_q) : '0;

  // Clamp the search length to 1..PALETTE_DEPTH and hand over the last index.
  always_comb begin
    if (palette_size_q == '0) begin
      last_idx_o = '0;
    end else if (palette_size_q >= PsizeW'(PALETTE_DEPTH)) begin
      last_idx_o = AddrW'(PALETTE_DEPTH - 1);
    end else begin
      last_idx_o = AddrW'(palette_size_q - PsizeW'(1));
    end
  end

  assign item_o.op          = op_e'(s_axis_tuser);
  assign item_o.entry_index = s_axis_tdata[7:0];
  assign item_o.red         = s_axis_tdata[15:8];
  assign item_o.green       = s_axis_tdata[23:16];
  assign item_o.blue        = s_axis_tdata[31:24];

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, item_o.entry_index} < PsizeW'(PALETTE_DEPTH));

  // Drop writes aimed past the end of the palette.
  assign push_o = accept && ((item_o.op == OP_MAP) || in_range);

endmodule

[rtl/core/npcm_fifo.sv]
`include "nearest_palette_color_mapper_top_macros.svh"

module npcm_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  npcm_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output npcm_pkg::item_t item_o
);
  import npcm_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `NPCM_NEVER(a_no_push_full, push_i && full_o, "push into full queue")
  `NPCM_NEVER(a_no_pop_empty, pop_i && empty_o, "pop from empty queue")
  `NPCM_NEVER(a_count_bound, count_q > CntW'(DEPTH), "queue count past depth")

endmodule

[rtl/core/npcm_back.sv]
`include "nearest_palette_color_mapper_top_macros.svh"

module npcm_back #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  npcm_pkg::item_t                  item_i,
  output logic                             pop_o,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] last_idx_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [npcm_pkg::IndexW-1:0]      color_index_o,
  output logic [npcm_pkg::DistW-1:0]       distance_sq_o
);
  import npcm_pkg::*;

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);
  localparam int unsigned SqW   = 2 * ColorW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  function automatic logic [ColorW-1:0] abs_diff(input logic [ColorW-1:0] a,
                                                 input logic [ColorW-1:0] b);
    logic [ColorW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d;
  endfunction

  state_e state_q, state_d;

  logic [3*ColorW-1:0] mem [PALETTE_DEPTH];
  logic                mem_we;

  logic [AddrW-1:0]    addr_q, addr_d;
  logic [AddrW-1:0]    last_idx_q;
  logic [ColorW-1:0]   pix_r_q, pix_g_q, pix_b_q;
  logic                start_map;

  // Stage 1: registered palette read
  logic                rd_v_q, rd_last_q;
  logic [AddrW-1:0]    rd_idx_q;
  logic [3*ColorW-1:0] rd_data_q;

  // Stage 2: registered channel squares
  logic                sq_v_q, sq_last_q;
  logic [AddrW-1:0]    sq_idx_q;
  logic [SqW-1:0]      sq_r_q, sq_g_q, sq_b_q;
  logic [ColorW-1:0]   dr, dg, db;

  // Stage 3: sum and compare
  logic [DistW-1:0]    dist_sum;
  logic                take;
  logic [AddrW-1:0]    best_idx_q, best_idx_d;
  logic [DistW-1:0]    best_dist_q, best_dist_d;

  logic                out_valid_q, out_valid_d;
  logic [IndexW-1:0]   out_idx_q;
  logic [DistW-1:0]    out_dist_q;
  logic                finish;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i &&
                     ((item_i.op == OP_WRITE) || !out_valid_q);
  assign mem_we    = pop_o && (item_i.op == OP_WRITE);
  assign start_map = pop_o && (item_i.op == OP_MAP);
  assign finish    = sq_v_q && sq_last_q;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (start_map) begin
          addr_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + AddrW'(1);
        if (addr_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      sq_v_q    <= 1'b0;
      sq_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      rd_v_q    <= (state_q == ST_SCAN);
      rd_last_q <= (state_q == ST_SCAN) && (addr_q == last_idx_q);
      sq_v_q    <= rd_v_q;
      sq_last_q <= rd_v_q && rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[item_i.entry_index[AddrW-1:0]] <= {item_i.red, item_i.green, item_i.blue};
    end
    rd_data_q <= mem[addr_q];
  end

  assign dr = abs_diff(rd_data_q[3*ColorW-1:2*ColorW], pix_r_q);
  assign dg = abs_diff(rd_data_q[2*ColorW-1:ColorW], pix_g_q);
  assign db = abs_diff(rd_data_q[ColorW-1:0], pix_b_q);

  always_ff @(posedge clk_i) begin
    if (start_map) begin
      pix_r_q    <= item_i.red;
      pix_g_q    <= item_i.green;
      pix_b_q    <= item_i.blue;
      last_idx_q <= last_idx_i;
    end
    rd_idx_q <= addr_q;
    sq_idx_q <= rd_idx_q;
    sq_r_q   <= dr * dr;
    sq_g_q   <= dg * dg;
    sq_b_q   <= db * db;
  end

  assign dist_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  // Entry zero seeds the search; later entries win only when strictly closer.
  assign take     = (sq_idx_q == '0) || (dist_sum < best_dist_q);

  always_comb begin
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    if (sq_v_q && take) begin
      best_idx_d  = sq_idx_q;
      best_dist_d = dist_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (finish) begin
      out_idx_q  <= IndexW'(best_idx_d);
      out_dist_q <= best_dist_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = out_idx_q;
  assign distance_sq_o = out_dist_q;

  `NPCM_NEVER(a_map_over_result, start_map && out_valid_q, "map started over held result")
  `NPCM_ASSERT(a_last_in_drain, finish |-> (state_q == ST_DRAIN), "scan end outside drain")
  `NPCM_ASSERT(a_result_from_drain, $rose(out_valid_q) |-> $past(state_q == ST_DRAIN),
               "result raised outside drain")
  `NPCM_NEVER(a_write_during_scan, mem_we && (rd_v_q || sq_v_q), "palette write mid scan")

endmodule

[rtl/core/nearest_palette_color_mapper_top.sv]
// Nearest palette color mapper: a palette write is applied to the palette RAM as it is popped from the queue.
// A map scans N entries in the back end (N = clamped palette_size, 1..PALETTE_DEPTH):
// one palette read per cycle from the palette RAM sets the pace.
// The back end takes no new map until the last one has finished and its result has been taken.
// Reset is asynchronous active low: clears control and queue, sets palette_size to 256.
// Palette contents are not cleared by reset; entries must be written before use.
module nearest_palette_color_mapper_top #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index [7:0], red [15:8], green [23:16], blue [31:24]
  input  logic [31:0]                   s_axis_tdata,
  // op [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // color_index [7:0], distance_sq [25:8], zero [31:26]
  output logic [31:0]                   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [npcm_pkg::PaddrW-1:0]   paddr,
  input  logic [npcm_pkg::ApbDataW-1:0] pwdata,
  output logic [npcm_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import npcm_pkg::*;

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);

  item_t             push_item, head_item;
  logic              push, pop, full, empty;
  logic [AddrW-1:0]  last_idx;
  logic [IndexW-1:0] color_index;
  logic [DistW-1:0]  distance_sq;

  npcm_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (full),
    .last_idx_o   (last_idx)
  );

  npcm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (head_item)
  );

  npcm_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .item_i       (head_item),
    .pop_o        (pop),
    .last_idx_i   (last_idx),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .color_index_o(color_index),
    .distance_sq_o(distance_sq)
  );

  assign m_axis_tdata = {6'b0, distance_sq, color_index};

endmodule

[dv/tb_nearest_palette_color_mapper_top.sv]
module tb_nearest_palette_color_mapper_top;
  import npcm_pkg::*;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned QueueDepth   = 4;
  // margin sized from the longest map, a scan of all PaletteDepth entries
  localparam int unsigned DrainCycles  = PaletteDepth + 16;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned StallLimit   = 4000;

  localparam logic [PaddrW-1:0] PaletteSizeAddr = '0;

  localparam int unsigned NumPhases  = 12;
  localparam int unsigned HoldPhase  = 4;
  localparam int unsigned PausePhase = 5;
  localparam int unsigned FillPhase  = 7;
  localparam logic [PsizeW-1:0] PhaseSize [NumPhases] = '{
    9'd1, 9'd0, 9'd2, 9'd7, 9'd5, 9'd16, 9'd33, 9'd256, 9'd511, 9'd100, 9'd257, 9'd12
  };

  typedef struct packed {
    logic [IndexW-1:0] color_index;
    logic [DistW-1:0]  distance_sq;
  } map_result_t;

  typedef struct packed {
    logic        typed;
    map_result_t want;
  } result_tag_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [PsizeW-1:0] size;
    item_t             itm;
    logic              typed;
    map_result_t       want;
  } dir_row_t;

  localparam int unsigned NumDirRows = 19;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // size zero searches entry 0 only
    '{ROW_CFG,  9'd0, '0, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 18'd195075}},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 18'd0}},
    '{ROW_ITEM, 9'd0, '{OP_WRITE, 8'd1, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 18'd195075}},
    '{ROW_CFG,  9'd2, '0, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd1, 18'd0}},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd128, 8'd128, 8'd128}, 1'b0, '0},
    // duplicate of entry 0 for a tie
    '{ROW_ITEM, 9'd0, '{OP_WRITE, 8'd2, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_CFG,  9'd3, '0, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd1, 8'd1, 8'd1}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_WRITE, 8'd255, 8'd170, 8'd85, 8'd170}, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_WRITE, 8'd3, 8'd10, 8'd20, 8'd30}, 1'b0, '0},
    '{ROW_CFG,  9'd4, '0, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd10, 8'd20, 8'd30}, 1'b1, '{8'd3, 18'd0}},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd85, 8'd170, 8'd85}, 1'b0, '0},
    '{ROW_CFG,  9'd1, '0, 1'b0, '0},
    '{ROW_ITEM, 9'd0, '{OP_MAP, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b1, '{8'd0, 18'd65025}}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PaddrW-1:0]   paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // predictor state, updated on accepted transfers
  logic [23:0]       pal_model [PaletteDepth];
  logic [PsizeW-1:0] pal_size = PsizeReset;
  map_result_t       nearest_q [$];
  result_tag_t       pending_tags [$];

  // stimulus-side view of the palette, updated when an item is offered
  logic [23:0] gen_pal [PaletteDepth];
  bit          gen_written [PaletteDepth];

  bit          calm          = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;

  nearest_palette_color_mapper_top #(
    .PALETTE_DEPTH(PaletteDepth),
    .QUEUE_DEPTH  (QueueDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned search_len(logic [PsizeW-1:0] sz);
    if (sz == 0) return 1;
    if (sz > PaletteDepth) return PaletteDepth;
    return sz;
  endfunction

  function automatic map_result_t nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    map_result_t res;
    int          dr, dg, db;
    int unsigned d, best_d;
    res    = '0;
    best_d = '1;
    for (int unsigned e = 0; e < search_len(pal_size); e++) begin
      dr = int'(pal_model[e][23:16]) - int'(r);
      dg = int'(pal_model[e][15:8]) - int'(g);
      db = int'(pal_model[e][7:0]) - int'(b);
      d  = dr * dr + dg * dg + db * db;
      // strictly smaller only: lowest index wins ties
      if (d < best_d) begin
        best_d          = d;
        res.color_index = IndexW'(e);
      end
    end
    res.distance_sq = best_d[DistW-1:0];
    return res;
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic item_t next_item(int unsigned span);
    item_t       it;
    int unsigned hole, src, mode;
    hole = span;
    for (int unsigned e = 0; e < span; e++) begin
      if (!gen_written[e] && hole == span) hole = e;
    end
    it.op          = OP_WRITE;
    it.entry_index = 8'($urandom_range(0, 255));
    it.red         = 8'($urandom);
    it.green       = 8'($urandom);
    it.blue        = 8'($urandom);
    src            = $urandom_range(0, PaletteDepth - 1);
    if ($urandom_range(0, 9) < 6) begin
      // fill holes first so a map never searches an unwritten entry
      if (hole < span) begin
        it.entry_index = IndexW'(hole);
      end else begin
        it.op = OP_MAP;
        src   = $urandom_range(0, span - 1);
        mode  = $urandom_range(0, 2);
        if (mode == 1) begin
          it.red   = jitter(gen_pal[src][23:16]);
          it.green = jitter(gen_pal[src][15:8]);
          it.blue  = jitter(gen_pal[src][7:0]);
        end else if (mode == 2) begin
          it.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
          it.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
          it.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
      end
    end
    // copy an existing color now and then to force ties
    if (it.op == OP_WRITE && gen_written[src] && $urandom_range(0, 3) == 0) begin
      {it.red, it.green, it.blue} = gen_pal[src];
    end
    return it;
  endfunction

  task automatic send_item(input item_t itm, input logic typed, input map_result_t want);
    pending_tags.insert(pending_tags.size(), result_tag_t'{typed, want});
    if (itm.op == OP_WRITE) begin
      gen_written[itm.entry_index] = 1'b1;
      gen_pal[itm.entry_index]     = {itm.red, itm.green, itm.blue};
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= itm.op;
    s_axis_tdata  <= {itm.blue, itm.green, itm.red, itm.entry_index};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_tags.size() != 0 || nearest_q.size() != 0) @(posedge clk_i);
    // a trailing palette write may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PaletteSizeAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_palette_size(input logic [PsizeW-1:0] want);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== ApbDataW'(want)) begin
      $display("%0t: palette_size readback expected %0d, got %0d", $time, want, rd);
      mismatches++;
    end
  endtask

  task automatic set_palette_size(input logic [PsizeW-1:0] value);
    logic [ApbDataW-1:0] unused;
    wait_drained();
    apb_access(1'b1, ApbDataW'(value), unused);
    pal_size = value;
    check_palette_size(value);
  endtask

  // predict on every accepted input transfer
  always @(posedge clk_i) begin : item_track
    result_tag_t tag;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tag = (pending_tags.size() != 0) ? pending_tags.pop_front() : '0;
      if (s_axis_tuser == OP_WRITE) begin
        pal_model[s_axis_tdata[7:0]] = {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                        s_axis_tdata[31:24]};
      end else if (tag.typed) begin
        nearest_q.insert(nearest_q.size(), tag.want);
      end else begin
        nearest_q.insert(nearest_q.size(), nearest_entry(s_axis_tdata[15:8],
                                                         s_axis_tdata[23:16],
                                                         s_axis_tdata[31:24]));
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    map_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = nearest_q.pop_front();
        if (m_axis_tdata[7:0] !== want.color_index) begin
          $display("%0t: color_index expected %0d, got %0d", $time, want.color_index,
                   m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[25:8] !== want.distance_sq) begin
          $display("%0t: distance_sq expected %0d, got %0d", $time, want.distance_sq,
                   m_axis_tdata[25:8]);
          mismatches++;
        end
        if (m_axis_tdata[31:26] !== '0) begin
          $display("%0t: tdata padding expected 0, got %h", $time, m_axis_tdata[31:26]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_nearest_palette_color_mapper_top: FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned served;
    served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != served) begin
        // long hold-off: let the block fill up and stall its input
        served = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_palette_size(PsizeReset);

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == ROW_CFG) begin
        set_palette_size(DirRows[i].size);
      end else begin
        send_item(DirRows[i].itm, DirRows[i].typed, DirRows[i].want);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) calm = 1'b1;
      set_palette_size(PhaseSize[p]);
      if (p == HoldPhase) hold_requests++;
      n_items = (p == FillPhase) ? 300 : 36;
      for (int unsigned k = 0; k < n_items; k++) begin
        if (p == PausePhase && k == n_items / 2) wait_drained();
        send_item(next_item(search_len(PhaseSize[p])), 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_nearest_palette_color_mapper_top: PASS");
    end else begin
      $display("tb_nearest_palette_color_mapper_top: FAIL");
    end
    $finish;
  end

endmodule
